// ===== rtl/fpr_pkg.sv =====
// Shared types and constants of the framed packet receiver.
`timescale 1ns / 1ps

package fpr_pkg;

    // Byte and field widths
    localparam int BYTE_W            = 8;
    localparam int LEN_W             = 16;
    localparam int OUT_PAYLOAD_BYTES = 4;

    // Default configuration
    localparam int          PAYLOAD_BYTES_DEFAULT = 4;
    localparam logic [7:0]  SYNC_RESET            = 8'hFD;

    // Parser phases, one-hot
    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_TYPE = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_DATA = 5'b01000,
        PH_CSUM = 5'b10000
    } phase_t;

    // Control state of the parser, store excluded
    typedef struct packed {
        phase_t              phase;
        logic                length_high_seen;
        logic [LEN_W-1:0]    data_length;
        logic [LEN_W-1:0]    data_count;
        logic [BYTE_W-1:0]   running_sum;
    } parse_state_t;

endpackage

// ===== rtl/fpr_step.sv =====
// Next-state logic of the parser for one received byte.
`timescale 1ns / 1ps

module fpr_step #(
    parameter int PAYLOAD_BYTES = fpr_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  fpr_pkg::parse_state_t               state,
    input  logic [fpr_pkg::BYTE_W-1:0]          rx_byte,
    input  logic [fpr_pkg::BYTE_W-1:0]          sync_value,
    output fpr_pkg::parse_state_t               state_next,
    output logic [PAYLOAD_BYTES-1:0]            store_we,
    output logic                                emit
);

    logic                       store_any;
    logic [fpr_pkg::LEN_W:0]    count_plus_one;
    logic                       more_data;

    // Compare the data position against the length with one spare bit
    assign count_plus_one = {1'b0, state.data_count} + (fpr_pkg::LEN_W + 1)'(1);
    assign more_data      = count_plus_one < {1'b0, state.data_length};

    // Advance the phase and the running fields
    always_comb
    begin
        state_next = state;
        store_any  = 1'b0;
        emit       = 1'b0;
        unique case (state.phase)
            fpr_pkg::PH_TYPE:
            begin
                state_next.phase = (rx_byte != '0) ? fpr_pkg::PH_LEN : fpr_pkg::PH_HUNT;
            end
            fpr_pkg::PH_LEN:
            begin
                state_next.running_sum = state.running_sum + rx_byte;
                if (!state.length_high_seen)
                begin
                    state_next.data_length      = {rx_byte, {fpr_pkg::BYTE_W{1'b0}}};
                    state_next.length_high_seen = 1'b1;
                end
                else
                begin
                    state_next.data_length = {state.data_length[fpr_pkg::LEN_W-1:fpr_pkg::BYTE_W],
                                              rx_byte};
                    state_next.phase       = fpr_pkg::PH_DATA;
                end
            end
            fpr_pkg::PH_DATA:
            begin
                if (state.data_length == '0)
                begin
                    // Drop the byte after a zero length
                    state_next.phase = fpr_pkg::PH_HUNT;
                end
                else
                begin
                    state_next.running_sum = state.running_sum + rx_byte;
                    store_any              = 1'b1;
                    if (more_data)
                        state_next.data_count = state.data_count + fpr_pkg::LEN_W'(1);
                    else
                        state_next.phase = fpr_pkg::PH_CSUM;
                end
            end
            fpr_pkg::PH_CSUM:
            begin
                emit             = (state.running_sum == rx_byte);
                state_next.phase = fpr_pkg::PH_HUNT;
            end
            default:
            begin
                // Hunt for sync; unused codes land here too
                state_next.length_high_seen = 1'b0;
                state_next.data_length      = '0;
                state_next.data_count       = '0;
                state_next.running_sum      = '0;
                state_next.phase = (rx_byte == sync_value) ? fpr_pkg::PH_TYPE
                                                           : fpr_pkg::PH_HUNT;
            end
        endcase
    end

    // Select the store entry at the current data position
    always_comb
    begin
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            store_we[i] = store_any && (state.data_count == fpr_pkg::LEN_W'(i));
    end

endmodule

// ===== rtl/framed_packet_receiver.sv =====
// Top level of the framed packet receiver: state, payload store and result register.
// A result appears in the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle unless a waiting result stalls input; the single-step parser update sets the rate.
// A waiting result holds off new bytes until out_ready takes it; a result taken
// in the same cycle frees the slot at once.
// Reset (rst_n low, asynchronous) returns to sync hunting, clears the store
// and restores sync_value to 0xFD.
`timescale 1ns / 1ps

module framed_packet_receiver #(
    parameter int PAYLOAD_BYTES = fpr_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fpr_pkg::BYTE_W-1:0]      sync_value,
    // Byte input
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fpr_pkg::BYTE_W-1:0]      rx_byte,
    // Frame output
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fpr_pkg::BYTE_W-1:0]      payload_0,
    output logic [fpr_pkg::BYTE_W-1:0]      payload_1,
    output logic [fpr_pkg::BYTE_W-1:0]      payload_2,
    output logic [fpr_pkg::BYTE_W-1:0]      payload_3,
    output logic [fpr_pkg::LEN_W-1:0]       frame_length
);

    logic [fpr_pkg::BYTE_W-1:0]                             sync_reg;
    fpr_pkg::parse_state_t                                  state_reg;
    fpr_pkg::parse_state_t                                  state_next;
    logic [PAYLOAD_BYTES-1:0][fpr_pkg::BYTE_W-1:0]          store_reg;
    logic [PAYLOAD_BYTES-1:0]                               store_we;
    logic                                                   emit;
    logic                                                   accept;
    logic [fpr_pkg::OUT_PAYLOAD_BYTES-1:0][fpr_pkg::BYTE_W-1:0] frame_bytes;
    logic [fpr_pkg::OUT_PAYLOAD_BYTES-1:0][fpr_pkg::BYTE_W-1:0] payload_reg;
    logic [fpr_pkg::LEN_W-1:0]                              length_reg;
    logic                                                   out_valid_reg;

    // Take a byte whenever the result register is free or draining
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    fpr_step #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_step (
        .state      (state_reg),
        .rx_byte    (rx_byte),
        .sync_value (sync_reg),
        .state_next (state_next),
        .store_we   (store_we),
        .emit       (emit)
    );

    // Map store entries to the fixed output fields; absent entries read zero
    genvar g;
    generate
        for (g = 0; g < fpr_pkg::OUT_PAYLOAD_BYTES; g++)
        begin : g_frame
            if (g < PAYLOAD_BYTES)
            begin : g_used
                assign frame_bytes[g] = store_reg[g];
            end
            else
            begin : g_unused
                assign frame_bytes[g] = '0;
            end
        end
    endgenerate

    // Hold the sync register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sync_reg <= fpr_pkg::SYNC_RESET;
        else if (cfg_valid && cfg_ready)
            sync_reg <= sync_value;
    end

    // Advance the parser state and write the payload store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase            <= fpr_pkg::PH_HUNT;
            state_reg.length_high_seen <= 1'b0;
            state_reg.data_length      <= '0;
            state_reg.data_count       <= '0;
            state_reg.running_sum      <= '0;
            store_reg                  <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            for (int i = 0; i < PAYLOAD_BYTES; i++)
            begin
                if (store_we[i])
                    store_reg[i] <= rx_byte;
            end
        end
    end

    // Load a finished frame request into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            payload_reg <= frame_bytes;
            length_reg  <= state_reg.data_length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_0    = payload_reg[0];
    assign payload_1    = payload_reg[1];
    assign payload_2    = payload_reg[2];
    assign payload_3    = payload_reg[3];
    assign frame_length = length_reg;

endmodule

// ===== verif/fpr_frame_checker.sv =====
// Frame checker of the framed packet receiver: parser prediction and result comparison.
`timescale 1ns / 1ps

module fpr_frame_checker #(
    parameter int PAYLOAD_BYTES = fpr_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [fpr_pkg::BYTE_W-1:0]      cfg_sync,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [fpr_pkg::BYTE_W-1:0]      rx_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [fpr_pkg::BYTE_W-1:0]      payload_0,
    input  logic [fpr_pkg::BYTE_W-1:0]      payload_1,
    input  logic [fpr_pkg::BYTE_W-1:0]      payload_2,
    input  logic [fpr_pkg::BYTE_W-1:0]      payload_3,
    input  logic [fpr_pkg::LEN_W-1:0]       frame_length,
    output int                              fail_count,
    output int                              pending
);

    typedef struct packed {
        logic [fpr_pkg::BYTE_W-1:0] p0;
        logic [fpr_pkg::BYTE_W-1:0] p1;
        logic [fpr_pkg::BYTE_W-1:0] p2;
        logic [fpr_pkg::BYTE_W-1:0] p3;
        logic [fpr_pkg::LEN_W-1:0]  len;
    } frame_t;

    // Frames the parser is expected to deliver, oldest first
    frame_t expected_frames[$];

    // Own copy of the parser state and the sync register
    fpr_pkg::phase_t            ph;
    logic                       len_hi_done;
    logic [fpr_pkg::LEN_W-1:0]  want_len;
    logic [fpr_pkg::LEN_W-1:0]  got_count;
    logic [fpr_pkg::BYTE_W-1:0] csum;
    logic [fpr_pkg::BYTE_W-1:0] sync_cur;
    logic [fpr_pkg::BYTE_W-1:0] store_q [0:3];
    int                         errors;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: frame mismatch on %s: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    // Advance the parser by one received byte; queue a frame on a good checksum
    task automatic parse_byte(input logic [fpr_pkg::BYTE_W-1:0] b);
        frame_t f;
        case (ph)
            fpr_pkg::PH_TYPE: ph = (b != 8'h00) ? fpr_pkg::PH_LEN : fpr_pkg::PH_HUNT;
            fpr_pkg::PH_LEN:
            begin
                csum = csum + b;
                if (!len_hi_done)
                begin
                    want_len    = {b, 8'h00};
                    len_hi_done = 1'b1;
                end
                else
                begin
                    want_len = want_len | {8'h00, b};
                    ph       = fpr_pkg::PH_DATA;
                end
            end
            fpr_pkg::PH_DATA:
            begin
                if (want_len == '0)
                    ph = fpr_pkg::PH_HUNT;
                else
                begin
                    csum = csum + b;
                    if (got_count < PAYLOAD_BYTES && got_count < 4)
                        store_q[got_count[1:0]] = b;
                    if ({1'b0, got_count} + 17'd1 < {1'b0, want_len})
                        got_count = got_count + 16'd1;
                    else
                        ph = fpr_pkg::PH_CSUM;
                end
            end
            fpr_pkg::PH_CSUM:
            begin
                if (csum == b)
                begin
                    f.p0  = (PAYLOAD_BYTES > 0) ? store_q[0] : 8'h00;
                    f.p1  = (PAYLOAD_BYTES > 1) ? store_q[1] : 8'h00;
                    f.p2  = (PAYLOAD_BYTES > 2) ? store_q[2] : 8'h00;
                    f.p3  = (PAYLOAD_BYTES > 3) ? store_q[3] : 8'h00;
                    f.len = want_len;
                    expected_frames.push_back(f);
                end
                ph = fpr_pkg::PH_HUNT;
            end
            default:
            begin
                // Hunt: clear the frame counters, start on the sync byte
                len_hi_done = 1'b0;
                want_len    = '0;
                got_count   = '0;
                csum        = '0;
                ph          = (b == sync_cur) ? fpr_pkg::PH_TYPE : fpr_pkg::PH_HUNT;
            end
        endcase
    endtask

    // Compare delivered frames, predict from accepted bytes, track the sync register
    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            ph          = fpr_pkg::PH_HUNT;
            len_hi_done = 1'b0;
            want_len    = '0;
            got_count   = '0;
            csum        = '0;
            sync_cur    = fpr_pkg::SYNC_RESET;
            for (int i = 0; i < 4; i++)
                store_q[i] = 8'h00;
            expected_frames.delete();
            errors = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                    report_mismatch("unexpected frame, length", frame_length, 0);
                else
                begin
                    want = expected_frames.pop_front();
                    if (payload_0 !== want.p0)
                        report_mismatch("payload_0", payload_0, want.p0);
                    if (payload_1 !== want.p1)
                        report_mismatch("payload_1", payload_1, want.p1);
                    if (payload_2 !== want.p2)
                        report_mismatch("payload_2", payload_2, want.p2);
                    if (payload_3 !== want.p3)
                        report_mismatch("payload_3", payload_3, want.p3);
                    if (frame_length !== want.len)
                        report_mismatch("frame_length", frame_length, want.len);
                end
            end
            // The byte taken at this edge still sees the old sync value
            if (in_valid && in_ready)
                parse_byte(rx_byte);
            if (cfg_valid && cfg_ready)
                sync_cur = cfg_sync;
            fail_count <= errors;
            pending    <= expected_frames.size();
        end
    end

endmodule

// ===== verif/framed_packet_receiver_tb.sv =====
// Testbench top of the framed packet receiver: clock, reset, byte and sync stimulus, verdict.
`timescale 1ns / 1ps

module framed_packet_receiver_tb;

    logic                       clk;
    logic                       rst_n        = 1'b0;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [fpr_pkg::BYTE_W-1:0] sync_value   = fpr_pkg::SYNC_RESET;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic [fpr_pkg::BYTE_W-1:0] rx_byte      = 8'h00;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic [fpr_pkg::BYTE_W-1:0] payload_0;
    logic [fpr_pkg::BYTE_W-1:0] payload_1;
    logic [fpr_pkg::BYTE_W-1:0] payload_2;
    logic [fpr_pkg::BYTE_W-1:0] payload_3;
    logic [fpr_pkg::LEN_W-1:0]  frame_length;

    int                         fail_count;
    int                         pending;
    int                         bytes_sent   = 0;
    bit                         steady       = 1'b0;
    logic [fpr_pkg::BYTE_W-1:0] cur_sync     = fpr_pkg::SYNC_RESET;

    framed_packet_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .sync_value   (sync_value),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .payload_0    (payload_0),
        .payload_1    (payload_1),
        .payload_2    (payload_2),
        .payload_3    (payload_3),
        .frame_length (frame_length)
    );

    fpr_frame_checker frame_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_sync     (sync_value),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .payload_0    (payload_0),
        .payload_1    (payload_1),
        .payload_2    (payload_2),
        .payload_3    (payload_3),
        .frame_length (frame_length),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the frame output at random, except during the steady stretch
    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 31);

    // Abort a hung run
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one byte after a random gap and hold it until accepted
    task automatic push_byte(input logic [fpr_pkg::BYTE_W-1:0] b);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Send sync, type, length, random data and a right or wrong checksum
    task automatic send_frame(input logic [fpr_pkg::BYTE_W-1:0] kind,
                              input logic [fpr_pkg::LEN_W-1:0] len,
                              input bit bad_sum);
        logic [fpr_pkg::BYTE_W-1:0] sum;
        logic [fpr_pkg::BYTE_W-1:0] d;
        push_byte(cur_sync);
        push_byte(kind);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        sum = len[15:8] + len[7:0];
        for (int i = 0; i < len; i++)
        begin
            d   = 8'($urandom);
            sum = sum + d;
            push_byte(d);
        end
        if (bad_sum)
            sum = sum + 8'($urandom_range(1, 255));
        push_byte(sum);
    endtask

    // Drop valid, let the outstanding frames drain, then let the pipeline settle
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        for (int n = 0; n < 4000 && pending != 0; n++)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_sync(input logic [fpr_pkg::BYTE_W-1:0] v);
        @(negedge clk);
        cfg_valid  <= 1'b1;
        sync_value <= v;
        do @(posedge clk); while (!cfg_ready);
        cur_sync = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [fpr_pkg::BYTE_W-1:0] sync_plan [0:4];
        logic [fpr_pkg::BYTE_W-1:0] kind;
        logic [fpr_pkg::BYTE_W-1:0] d;
        logic [fpr_pkg::LEN_W-1:0]  len;
        int                         pick;
        int                         target;

        sync_plan[0] = fpr_pkg::SYNC_RESET;
        sync_plan[1] = 8'h00;
        sync_plan[2] = 8'hFF;
        sync_plan[3] = 8'($urandom);
        sync_plan[4] = fpr_pkg::SYNC_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Long frame past the store, with the largest type byte
        send_frame(8'hFF, 16'd5, 1'b0);
        // Short frame: stale store entries from the long one stay visible
        send_frame(8'h01, 16'd1, 1'b0);
        // Zero type byte drops back to hunting
        push_byte(cur_sync);
        push_byte(8'h00);
        // Zero length: the next byte is dropped
        send_frame(8'h01, 16'd0, 1'b0);
        // Checksum mismatch
        send_frame(8'h7F, 16'd1, 1'b1);

        for (int phase_no = 0; phase_no < 5; phase_no++)
        begin
            if (phase_no != 0)
            begin
                wait_quiet();
                write_sync(sync_plan[phase_no]);
            end
            steady = (phase_no == 2);
            target = bytes_sent + 60;
            while (bytes_sent < target)
            begin
                pick = $urandom_range(0, 99);
                kind = 8'($urandom_range(1, 255));
                len  = ($urandom_range(0, 99) < 2) ? 16'($urandom_range(256, 300))
                                                   : 16'($urandom_range(1, 9));
                if (pick < 65)
                    send_frame(kind, len, 1'b0);
                else if (pick < 75)
                    send_frame(kind, len, 1'b1);
                else if (pick < 80)
                begin
                    push_byte(cur_sync);
                    push_byte(8'h00);
                end
                else if (pick < 85)
                    send_frame(kind, 16'd0, 1'b0);
                else
                begin
                    // Line noise between frames, kept off the sync value
                    repeat ($urandom_range(1, 4))
                    begin
                        do d = 8'($urandom); while (d == cur_sync);
                        push_byte(d);
                    end
                end
            end
        end
        steady = 1'b0;

        wait_quiet();
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fpr_pkg.sv
rtl/fpr_step.sv
rtl/framed_packet_receiver.sv
verif/fpr_frame_checker.sv
verif/framed_packet_receiver_tb.sv
